>>> rtl/coherence_directory_entry_table_top_macros.svh
// ----------------------------------------------------------------------------
// Directory entry table assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef COHERENCE_DIRECTORY_ENTRY_TABLE_TOP_MACROS_SVH
`define COHERENCE_DIRECTORY_ENTRY_TABLE_TOP_MACROS_SVH

// Check post in the same cycle as pre.
`define CDET_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cdet: same-cycle check failed");

// Check post in the cycle after pre.
`define CDET_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cdet: next-cycle check failed");

`endif

>>> rtl/cdet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdet_pkg
// Shared widths, codes, types and sizing functions of the directory table.
// ----------------------------------------------------------------------------
package cdet_pkg;

  localparam int MODE_W      = 3;
  localparam int SET_W       = 6;
  localparam int WAY_W       = 3;
  localparam int SUB_W       = 2;
  localparam int NODE_W      = 4;
  localparam int CNT_W       = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int MASK_OUT_W  = 16;

  localparam int DEF_NUM_SETS      = 64;
  localparam int DEF_NUM_WAYS      = 8;
  localparam int DEF_NUM_SUBBLOCKS = 4;
  localparam int DEF_NODE_COUNT    = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_OWNER    = 3'd0,
    MODE_CLEAR_OWNER  = 3'd1,
    MODE_ADD_SHARER   = 3'd2,
    MODE_REMOVE_SHARER = 3'd3,
    MODE_CLEAR_ALL    = 3'd4,
    MODE_QUERY_SHARER = 3'd5,
    MODE_QUERY_GROUP  = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    logic clear_we;
    logic rd_en;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic                   flag;
    logic                   owner_valid;
    logic [NODE_W-1:0]      owner_node;
    logic [COUNT_OUT_W-1:0] sharer_count;
    logic [MASK_OUT_W-1:0]  sharer_mask;
    logic [CNT_W-1:0]       add_requests;
    logic [CNT_W-1:0]       remove_requests;
    logic [CNT_W-1:0]       full_invalidations;
  } rsp_t;

  function automatic int count_width(input int nodes);
    return $clog2(nodes + 1);
  endfunction

  function automatic int entry_width(input int nodes);
    return 1 + NODE_W + nodes + count_width(nodes) + 3 * CNT_W;
  endfunction

endpackage

>>> rtl/cdet_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdet_if
// Valid/ready channels for directory requests and results.
// ----------------------------------------------------------------------------
interface cdet_req_if;
  logic                          valid;
  logic                          ready;
  logic [cdet_pkg::MODE_W-1:0]   mode;
  logic [cdet_pkg::SET_W-1:0]    set_index;
  logic [cdet_pkg::WAY_W-1:0]    way_index;
  logic [cdet_pkg::SUB_W-1:0]    subblock_index;
  logic [cdet_pkg::NODE_W-1:0]   node;

  modport source (
    output valid, mode, set_index, way_index, subblock_index, node,
    input  ready
  );
  modport sink (
    input  valid, mode, set_index, way_index, subblock_index, node,
    output ready
  );
endinterface

interface cdet_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              flag;
  logic                              owner_valid;
  logic [cdet_pkg::NODE_W-1:0]       owner_node;
  logic [cdet_pkg::COUNT_OUT_W-1:0]  sharer_count;
  logic [cdet_pkg::MASK_OUT_W-1:0]   sharer_mask;
  logic [cdet_pkg::CNT_W-1:0]        add_requests;
  logic [cdet_pkg::CNT_W-1:0]        remove_requests;
  logic [cdet_pkg::CNT_W-1:0]        full_invalidations;

  modport source (
    output valid, flag, owner_valid, owner_node, sharer_count, sharer_mask,
           add_requests, remove_requests, full_invalidations,
    input  ready
  );
  modport sink (
    input  valid, flag, owner_valid, owner_node, sharer_count, sharer_mask,
           add_requests, remove_requests, full_invalidations,
    output ready
  );
endinterface

>>> rtl/cdet_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdet_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdet_ram #(
  parameter  int DEPTH = 512,
  parameter  int WIDTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cdet_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdet_update
// Applies one request to a row of subblock entries and forms the result.
// ----------------------------------------------------------------------------
module cdet_update #(
  parameter  int NUM_SUBBLOCKS = cdet_pkg::DEF_NUM_SUBBLOCKS,
  parameter  int NODE_COUNT    = cdet_pkg::DEF_NODE_COUNT,
  localparam int ROW_W         = NUM_SUBBLOCKS * cdet_pkg::entry_width(NODE_COUNT)
) (
  input  logic [ROW_W-1:0]              row_in,
  input  logic                          idx_ok,
  input  logic [cdet_pkg::MODE_W-1:0]   mode,
  input  logic [cdet_pkg::SUB_W-1:0]    subblock_index,
  input  logic [cdet_pkg::NODE_W-1:0]   node,
  output logic [ROW_W-1:0]              row_out,
  output logic                          wr_ok,
  output cdet_pkg::rsp_t                rsp
);

  localparam int CW  = cdet_pkg::count_width(NODE_COUNT);
  localparam int SBW = (NUM_SUBBLOCKS > 1) ? $clog2(NUM_SUBBLOCKS) : 1;
  localparam int MW  = (NODE_COUNT > cdet_pkg::MASK_OUT_W) ? NODE_COUNT : cdet_pkg::MASK_OUT_W;
  localparam int CWW = (CW > cdet_pkg::COUNT_OUT_W) ? CW : cdet_pkg::COUNT_OUT_W;

  typedef struct packed {
    logic                        owner_valid;
    logic [cdet_pkg::NODE_W-1:0] owner;
    logic [NODE_COUNT-1:0]       mask;
    logic [CW-1:0]               count;
    logic [cdet_pkg::CNT_W-1:0]  adds;
    logic [cdet_pkg::CNT_W-1:0]  removes;
    logic [cdet_pkg::CNT_W-1:0]  invals;
  } entry_t;

  entry_t [NUM_SUBBLOCKS-1:0] row;
  entry_t [NUM_SUBBLOCKS-1:0] row_upd;
  entry_t                     cur;
  entry_t                     upd;
  cdet_pkg::mode_e            op;
  logic [SBW-1:0]             sel;
  logic                       node_ok;
  logic                       sub_ok;
  logic                       has;
  logic                       group_hit;
  logic                       flag;
  logic [MW-1:0]              bit_wide;
  logic [NODE_COUNT-1:0]      node_bit;
  logic [MW-1:0]              mask_wide;
  logic [CWW-1:0]             count_wide;

  assign row     = row_in;
  assign row_out = row_upd;

  always_comb begin
    op       = cdet_pkg::mode_e'(mode);
    node_ok  = 32'(node) < NODE_COUNT;
    sub_ok   = (op == cdet_pkg::MODE_QUERY_GROUP) || (32'(subblock_index) < NUM_SUBBLOCKS);
    sel      = (op == cdet_pkg::MODE_QUERY_GROUP) ? '0 : SBW'(subblock_index);
    bit_wide = MW'(1) << node;
    node_bit = bit_wide[NODE_COUNT-1:0];
    cur      = row[sel];
    has      = |(cur.mask & node_bit);

    group_hit = 1'b0;
    for (int i = 0; i < NUM_SUBBLOCKS; i++) begin
      if (row[i].count != '0 || row[i].owner_valid) begin
        group_hit = 1'b1;
      end
    end

    upd  = cur;
    flag = 1'b0;
    unique case (op)
      cdet_pkg::MODE_SET_OWNER: begin
        if (node_ok) begin
          upd.owner_valid = 1'b1;
          upd.owner       = node;
        end
      end
      cdet_pkg::MODE_CLEAR_OWNER: begin
        upd.owner_valid = 1'b0;
        upd.owner       = '0;
      end
      cdet_pkg::MODE_ADD_SHARER: begin
        if (node_ok) begin
          upd.adds = (cur.adds == '1) ? cur.adds : cur.adds + cdet_pkg::CNT_W'(1);
          if (!has) begin
            upd.mask  = cur.mask | node_bit;
            upd.count = cur.count + CW'(1);
          end
        end
      end
      cdet_pkg::MODE_REMOVE_SHARER: begin
        if (node_ok) begin
          upd.removes = (cur.removes == '1) ? cur.removes
                                            : cur.removes + cdet_pkg::CNT_W'(1);
          if (has) begin
            upd.mask = cur.mask & ~node_bit;
            if (cur.count != '0) begin
              upd.count = cur.count - CW'(1);
            end
          end
        end
      end
      cdet_pkg::MODE_CLEAR_ALL: begin
        upd.mask   = '0;
        upd.count  = '0;
        upd.invals = (cur.invals == '1) ? cur.invals : cur.invals + cdet_pkg::CNT_W'(1);
      end
      cdet_pkg::MODE_QUERY_SHARER: begin
        flag = node_ok && has;
      end
      cdet_pkg::MODE_QUERY_GROUP: begin
        flag = group_hit;
      end
      default: begin
      end
    endcase

    row_upd      = row;
    row_upd[sel] = upd;
    wr_ok        = idx_ok && sub_ok;
    mask_wide    = MW'(upd.mask);
    count_wide   = CWW'(upd.count);

    rsp = '0;
    if (wr_ok) begin
      rsp.flag               = flag;
      rsp.owner_valid        = upd.owner_valid;
      rsp.owner_node         = upd.owner_valid ? upd.owner : '0;
      rsp.sharer_count       = count_wide[cdet_pkg::COUNT_OUT_W-1:0];
      rsp.sharer_mask        = mask_wide[cdet_pkg::MASK_OUT_W-1:0];
      rsp.add_requests       = upd.adds;
      rsp.remove_requests    = upd.removes;
      rsp.full_invalidations = upd.invals;
    end
  end

endmodule

>>> rtl/cdet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdet_ctrl
// Sequencer: clearing pass, read, modify/write-back and result handshake.
// ----------------------------------------------------------------------------
`include "coherence_directory_entry_table_top_macros.svh"

module cdet_ctrl #(
  parameter  int ROWS = cdet_pkg::DEF_NUM_SETS * cdet_pkg::DEF_NUM_WAYS,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [AW-1:0]  clear_addr,
  output cdet_pkg::ctl_t ctl
);

  cdet_pkg::state_t state;
  cdet_pkg::state_t state_next;
  logic             room;
  logic             last_row;

  assign room     = !out_valid || out_ready;
  assign last_row = clear_addr == AW'(ROWS - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      cdet_pkg::ST_CLEAR: begin
        if (last_row) begin
          state_next = cdet_pkg::ST_IDLE;
        end
      end
      cdet_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = cdet_pkg::ST_MODIFY;
        end
      end
      cdet_pkg::ST_MODIFY: begin
        if (room) begin
          state_next = cdet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdet_pkg::ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    unique case (state)
      cdet_pkg::ST_CLEAR: begin
        ctl.clear_we = 1'b1;
      end
      cdet_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        ctl.rd_en  = in_valid;
      end
      cdet_pkg::ST_MODIFY: begin
        ctl.commit = room;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cdet_pkg::ST_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.clear_we && !last_row) begin
        clear_addr <= clear_addr + AW'(1);
      end
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CDET_ASSERT_NOW(a_clear_blocks_input, state == cdet_pkg::ST_CLEAR, !in_ready)
  `CDET_ASSERT_NEXT(a_accept_then_modify, in_valid && in_ready, state == cdet_pkg::ST_MODIFY)
  `CDET_ASSERT_NEXT(a_commit_shows_result, ctl.commit, state == cdet_pkg::ST_IDLE && out_valid)
  `CDET_ASSERT_NOW(a_commit_has_room, ctl.commit, !out_valid || out_ready)

endmodule

>>> rtl/coherence_directory_entry_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coherence directory entry table
// Full-map directory: one entry per set, way and subblock, holding an owner,
// a sharer bitmap, a sharer count and three saturating event counters. All
// subblocks of one set and way share one wide row of a single memory, so a
// request costs one read and one write-back of that row. A request is accepted
// and its row read in IDLE, then modified and written back in MODIFY, which
// waits until the output register has room; the next request is taken in the
// cycle after the write-back, while the previous result may still wait in the
// output register. After reset a clearing pass writes every row, one row per
// cycle; no request is accepted until it ends.
// ----------------------------------------------------------------------------
module coherence_directory_entry_table_top #(
  parameter int NUM_SETS      = cdet_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS      = cdet_pkg::DEF_NUM_WAYS,
  parameter int NUM_SUBBLOCKS = cdet_pkg::DEF_NUM_SUBBLOCKS,
  parameter int NODE_COUNT    = cdet_pkg::DEF_NODE_COUNT
) (
  input  logic       clk,
  input  logic       rst,
  cdet_req_if.sink   req,
  cdet_rsp_if.source rsp
);

  localparam int ROWS  = NUM_SETS * NUM_WAYS;
  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_W = NUM_SUBBLOCKS * cdet_pkg::entry_width(NODE_COUNT);

  cdet_pkg::ctl_t              ctl;
  logic [AW-1:0]               clear_addr;
  logic [AW-1:0]               rd_addr;
  logic                        rd_ok;
  logic [AW-1:0]               row_addr;
  logic                        idx_ok;
  logic [cdet_pkg::MODE_W-1:0] mode;
  logic [cdet_pkg::SUB_W-1:0]  subblock_index;
  logic [cdet_pkg::NODE_W-1:0] node;
  logic [ROW_W-1:0]            row_rd;
  logic [ROW_W-1:0]            row_wr;
  logic                        wr_ok;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ROW_W-1:0]            ram_wdata;
  cdet_pkg::rsp_t              rsp_calc;
  cdet_pkg::rsp_t              result;

  assign rd_addr = AW'(32'(req.set_index) * NUM_WAYS + 32'(req.way_index));
  assign rd_ok   = (32'(req.set_index) < NUM_SETS) && (32'(req.way_index) < NUM_WAYS);

  // Hold the request across the memory read.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      row_addr       <= rd_addr;
      idx_ok         <= rd_ok;
      mode           <= req.mode;
      subblock_index <= req.subblock_index;
      node           <= req.node;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      result <= rsp_calc;
    end
  end

  assign ram_we    = ctl.clear_we || (ctl.commit && wr_ok);
  assign ram_waddr = ctl.clear_we ? clear_addr : row_addr;
  assign ram_wdata = ctl.clear_we ? '0 : row_wr;

  cdet_ctrl #(
    .ROWS (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .clear_addr (clear_addr),
    .ctl        (ctl)
  );

  cdet_ram #(
    .DEPTH (ROWS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (row_rd)
  );

  cdet_update #(
    .NUM_SUBBLOCKS (NUM_SUBBLOCKS),
    .NODE_COUNT    (NODE_COUNT)
  ) u_update (
    .row_in         (row_rd),
    .idx_ok         (idx_ok),
    .mode           (mode),
    .subblock_index (subblock_index),
    .node           (node),
    .row_out        (row_wr),
    .wr_ok          (wr_ok),
    .rsp            (rsp_calc)
  );

  assign rsp.flag               = result.flag;
  assign rsp.owner_valid        = result.owner_valid;
  assign rsp.owner_node         = result.owner_node;
  assign rsp.sharer_count       = result.sharer_count;
  assign rsp.sharer_mask        = result.sharer_mask;
  assign rsp.add_requests       = result.add_requests;
  assign rsp.remove_requests    = result.remove_requests;
  assign rsp.full_invalidations = result.full_invalidations;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Directory entry table testbench
// Drives owner, sharer, clear and query requests into the directory and
// checks every result against a cycle-free model of the entry table kept in
// the bench. Requests come from a queue. Both channels idle at random in the
// first two of three phases, and one long result stall backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ENTRIES      = cdet_pkg::DEF_NUM_SETS * cdet_pkg::DEF_NUM_WAYS *
                                cdet_pkg::DEF_NUM_SUBBLOCKS;
  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 400;
  localparam logic [cdet_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [cdet_pkg::MODE_W-1:0] mode;
    logic [cdet_pkg::SET_W-1:0]  set_index;
    logic [cdet_pkg::WAY_W-1:0]  way_index;
    logic [cdet_pkg::SUB_W-1:0]  subblock_index;
    logic [cdet_pkg::NODE_W-1:0] node;
  } dir_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdet_req_if req_ch ();
  cdet_rsp_if rsp_ch ();

  coherence_directory_entry_table_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // bench copy of the entry table
  bit                             dir_owner_v [ENTRIES];
  bit [cdet_pkg::NODE_W-1:0]      dir_owner_n [ENTRIES];
  bit [cdet_pkg::MASK_OUT_W-1:0]  dir_mask    [ENTRIES];
  bit [cdet_pkg::COUNT_OUT_W-1:0] dir_count   [ENTRIES];
  bit [cdet_pkg::CNT_W-1:0]       dir_adds    [ENTRIES];
  bit [cdet_pkg::CNT_W-1:0]       dir_removes [ENTRIES];
  bit [cdet_pkg::CNT_W-1:0]       dir_invals  [ENTRIES];

  dir_req_t       request_q [$];
  cdet_pkg::rsp_t entry_expect_q [$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_trigger = 1'b0;
  bit hold_done = 1'b0;

  function automatic bit [cdet_pkg::CNT_W-1:0] sat_inc(input bit [cdet_pkg::CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic cdet_pkg::rsp_t apply_request(input dir_req_t r);
    cdet_pkg::rsp_t o;
    logic [10:0] e;
    logic [10:0] q;
    bit node_ok;
    o = '0;
    node_ok = r.node < cdet_pkg::DEF_NODE_COUNT;
    if (r.set_index >= cdet_pkg::DEF_NUM_SETS || r.way_index >= cdet_pkg::DEF_NUM_WAYS)
      return o;
    if (r.mode == cdet_pkg::MODE_QUERY_GROUP) begin
      for (int z = 0; z < cdet_pkg::DEF_NUM_SUBBLOCKS; z++) begin
        q = {r.set_index, r.way_index, z[cdet_pkg::SUB_W-1:0]};
        if (dir_count[q] != 0 || dir_owner_v[q]) o.flag = 1'b1;
      end
      e = {r.set_index, r.way_index, {cdet_pkg::SUB_W{1'b0}}};
    end else begin
      if (r.subblock_index >= cdet_pkg::DEF_NUM_SUBBLOCKS) return o;
      e = {r.set_index, r.way_index, r.subblock_index};
      case (r.mode)
        cdet_pkg::MODE_SET_OWNER: begin
          if (node_ok) begin
            dir_owner_v[e] = 1'b1;
            dir_owner_n[e] = r.node;
          end
        end
        cdet_pkg::MODE_CLEAR_OWNER: begin
          dir_owner_v[e] = 1'b0;
          dir_owner_n[e] = '0;
        end
        cdet_pkg::MODE_ADD_SHARER: begin
          if (node_ok) begin
            dir_adds[e] = sat_inc(dir_adds[e]);
            if (!dir_mask[e][r.node]) begin
              dir_mask[e][r.node] = 1'b1;
              dir_count[e] = dir_count[e] + 1'b1;
            end
          end
        end
        cdet_pkg::MODE_REMOVE_SHARER: begin
          if (node_ok) begin
            dir_removes[e] = sat_inc(dir_removes[e]);
            if (dir_mask[e][r.node]) begin
              dir_mask[e][r.node] = 1'b0;
              if (dir_count[e] != 0) dir_count[e] = dir_count[e] - 1'b1;
            end
          end
        end
        cdet_pkg::MODE_CLEAR_ALL: begin
          dir_mask[e] = '0;
          dir_count[e] = '0;
          dir_invals[e] = sat_inc(dir_invals[e]);
        end
        cdet_pkg::MODE_QUERY_SHARER: begin
          if (node_ok && dir_mask[e][r.node]) o.flag = 1'b1;
        end
        default: ;
      endcase
    end
    o.owner_valid = dir_owner_v[e];
    o.owner_node = dir_owner_v[e] ? dir_owner_n[e] : '0;
    o.sharer_count = dir_count[e];
    o.sharer_mask = dir_mask[e];
    o.add_requests = dir_adds[e];
    o.remove_requests = dir_removes[e];
    o.full_invalidations = dir_invals[e];
    return o;
  endfunction

  // driver: hold a request until it is taken, then advance
  always @(posedge clk) begin
    dir_req_t cur;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= '0;
      req_ch.set_index <= '0;
      req_ch.way_index <= '0;
      req_ch.subblock_index <= '0;
      req_ch.node <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        cur.mode = req_ch.mode;
        cur.set_index = req_ch.set_index;
        cur.way_index = req_ch.way_index;
        cur.subblock_index = req_ch.subblock_index;
        cur.node = req_ch.node;
        entry_expect_q.push_back(apply_request(cur));
        void'(request_q.pop_front());
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          cur = request_q[0];
          req_ch.valid <= 1'b1;
          req_ch.mode <= cur.mode;
          req_ch.set_index <= cur.set_index;
          req_ch.way_index <= cur.way_index;
          req_ch.subblock_index <= cur.subblock_index;
          req_ch.node <= cur.node;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long result stall
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    cdet_pkg::rsp_t got;
    cdet_pkg::rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.flag = rsp_ch.flag;
        got.owner_valid = rsp_ch.owner_valid;
        got.owner_node = rsp_ch.owner_node;
        got.sharer_count = rsp_ch.sharer_count;
        got.sharer_mask = rsp_ch.sharer_mask;
        got.add_requests = rsp_ch.add_requests;
        got.remove_requests = rsp_ch.remove_requests;
        got.full_invalidations = rsp_ch.full_invalidations;
        if (entry_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: unexpected result at cycle %0d", cycles);
        end else begin
          want = entry_expect_q.pop_front();
          if (got.flag !== want.flag || got.owner_valid !== want.owner_valid ||
              got.owner_node !== want.owner_node ||
              got.sharer_count !== want.sharer_count ||
              got.sharer_mask !== want.sharer_mask ||
              got.add_requests !== want.add_requests ||
              got.remove_requests !== want.remove_requests ||
              got.full_invalidations !== want.full_invalidations) begin
            errors++;
            if (errors <= 10) begin
              $display("tb: mismatch at cycle %0d", cycles);
              $display("  exp flag %0d own %0d/%0d cnt %0d mask %h add %0d rem %0d inv %0d",
                       want.flag, want.owner_valid, want.owner_node, want.sharer_count,
                       want.sharer_mask, want.add_requests, want.remove_requests,
                       want.full_invalidations);
              $display("  act flag %0d own %0d/%0d cnt %0d mask %h add %0d rem %0d inv %0d",
                       got.flag, got.owner_valid, got.owner_node, got.sharer_count,
                       got.sharer_mask, got.add_requests, got.remove_requests,
                       got.full_invalidations);
            end
          end
        end
      end
      rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_req(input logic [cdet_pkg::MODE_W-1:0] m, input int s, input int w,
                          input int b, input int n);
    dir_req_t r;
    r.mode = m;
    r.set_index = s[cdet_pkg::SET_W-1:0];
    r.way_index = w[cdet_pkg::WAY_W-1:0];
    r.subblock_index = b[cdet_pkg::SUB_W-1:0];
    r.node = n[cdet_pkg::NODE_W-1:0];
    request_q.push_back(r);
  endtask

  // add every node to one entry in shuffled order, then query it
  task automatic push_fill(input int s, input int w, input int b);
    int order [16];
    int j;
    int t;
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 16; i++) push_req(cdet_pkg::MODE_ADD_SHARER, s, w, b, order[i]);
    push_req(cdet_pkg::MODE_QUERY_SHARER, s, w, b, $urandom_range(15));
    push_req(cdet_pkg::MODE_QUERY_GROUP, s, w, $urandom_range(3), 0);
  endtask

  function automatic logic [cdet_pkg::MODE_W-1:0] pick_mode();
    int p;
    p = $urandom_range(99);
    if (p < 40) return cdet_pkg::MODE_ADD_SHARER;
    if (p < 55) return cdet_pkg::MODE_REMOVE_SHARER;
    if (p < 65) return cdet_pkg::MODE_SET_OWNER;
    if (p < 71) return cdet_pkg::MODE_CLEAR_OWNER;
    if (p < 75) return cdet_pkg::MODE_CLEAR_ALL;
    if (p < 86) return cdet_pkg::MODE_QUERY_SHARER;
    if (p < 97) return cdet_pkg::MODE_QUERY_GROUP;
    return MODE_UNUSED;
  endfunction

  task automatic push_random(input int count);
    int hot_s [4];
    int hot_w [4];
    int hot_b [4];
    int k;
    int made;
    for (int i = 0; i < 4; i++) begin
      hot_s[i] = $urandom_range(63);
      hot_w[i] = $urandom_range(7);
      hot_b[i] = $urandom_range(3);
    end
    made = 0;
    while (made < count) begin
      k = $urandom_range(3);
      if ($urandom_range(99) < 3) begin
        push_fill(hot_s[k], hot_w[k], hot_b[k]);
        made += 18;
      end else if ($urandom_range(99) < 60) begin
        push_req(pick_mode(), hot_s[k], hot_w[k], hot_b[k], $urandom_range(15));
        made++;
      end else begin
        push_req(pick_mode(), $urandom_range(63), $urandom_range(7), $urandom_range(3),
                 $urandom_range(15));
        made++;
      end
    end
  endtask

  task automatic wait_drain();
    while (request_q.size() != 0 || entry_expect_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = '0;
    req_ch.set_index = '0;
    req_ch.way_index = '0;
    req_ch.subblock_index = '0;
    req_ch.node = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 22;
    recv_idle = 85;
    push_req(cdet_pkg::MODE_SET_OWNER, 63, 7, 3, 15);
    push_req(cdet_pkg::MODE_ADD_SHARER, 63, 7, 3, 0);
    push_req(cdet_pkg::MODE_ADD_SHARER, 63, 7, 3, 0);
    push_req(cdet_pkg::MODE_ADD_SHARER, 63, 7, 3, 15);
    push_req(cdet_pkg::MODE_QUERY_SHARER, 63, 7, 3, 15);
    push_req(cdet_pkg::MODE_QUERY_SHARER, 63, 7, 3, 3);
    push_req(cdet_pkg::MODE_REMOVE_SHARER, 63, 7, 3, 7);
    push_req(cdet_pkg::MODE_REMOVE_SHARER, 63, 7, 3, 0);
    push_req(cdet_pkg::MODE_QUERY_GROUP, 63, 7, 0, 0);
    push_req(cdet_pkg::MODE_QUERY_GROUP, 0, 0, 3, 15);
    push_req(cdet_pkg::MODE_CLEAR_ALL, 63, 7, 3, 0);
    push_req(cdet_pkg::MODE_QUERY_SHARER, 63, 7, 3, 15);
    push_req(cdet_pkg::MODE_CLEAR_OWNER, 63, 7, 3, 0);
    push_req(cdet_pkg::MODE_QUERY_GROUP, 63, 7, 3, 0);
    push_req(MODE_UNUSED, 63, 7, 3, 15);
    push_req(cdet_pkg::MODE_SET_OWNER, 0, 0, 0, 0);
    push_req(cdet_pkg::MODE_QUERY_GROUP, 0, 0, 2, 0);
    push_req(cdet_pkg::MODE_ADD_SHARER, 0, 0, 1, 9);
    push_req(cdet_pkg::MODE_CLEAR_OWNER, 0, 0, 0, 0);
    push_req(cdet_pkg::MODE_QUERY_GROUP, 0, 0, 3, 0);
    push_req(cdet_pkg::MODE_CLEAR_ALL, 0, 0, 1, 0);
    push_req(cdet_pkg::MODE_QUERY_GROUP, 0, 0, 1, 0);
    push_random(PHASE_ITEMS);
    wait_drain();

    send_idle = 85;
    recv_idle = 22;
    push_random(PHASE_ITEMS);
    wait_drain();

    send_idle = 0;
    recv_idle = 0;
    hold_trigger = 1'b1;
    push_random(PHASE_ITEMS);
    wait_drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && entry_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
